FILE: rtl/multichannel_peak_hold_score_top_defines.svh
// Assertion macros for the multichannel peak-hold score block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MULTICHANNEL_PEAK_HOLD_SCORE_TOP_DEFINES_SVH
`define MULTICHANNEL_PEAK_HOLD_SCORE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define MPHS_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("mphs check failed");
`define MPHS_ASSERT_NEVER(lbl, clk_s, rst_s, cond) \
  `MPHS_ASSERT(lbl, clk_s, rst_s, !(cond))
`else
`define MPHS_ASSERT(lbl, clk_s, rst_s, prop)
`define MPHS_ASSERT_NEVER(lbl, clk_s, rst_s, cond)
`endif

`endif

FILE: rtl/mphs_pkg.sv
// Shared widths, constants and types of the multichannel peak-hold score block.
// No dependencies; used by the interfaces and all RTL modules.
package mphs_pkg;

  localparam int CHANNELS_DEF = 25;
  localparam int CH_W         = 5;
  localparam int MAX_DEPTH    = 2 ** CH_W;   // channel field cannot address more
  localparam int SMP_W        = 8;
  localparam int PEAK_W       = 8;
  localparam int SUM_W        = 13;          // 32 * 255 still fits
  localparam int SCORE_W      = 10;
  localparam int DIG_W        = 4;
  localparam int QUEUE_DEPTH  = 4;

  // score = sum * 1000 / 6375 = (sum * 8) / 51
  localparam int SCORE_MAX    = 1000;
  localparam int SCALE_SHIFT  = 3;
  localparam int DIV_Q        = 51;
  localparam int RECIP        = 1285;        // floor(2^16 / 51)
  localparam int RECIP_SHIFT  = 16;
  localparam int X_W          = SUM_W + SCALE_SHIFT;
  localparam int Q0_W         = 11;
  localparam int PROD_W       = X_W + Q0_W;

  // decimal split
  localparam int HUND         = 100;
  localparam int TEN          = 10;
  localparam int HUND_RECIP   = 41;          // n/100 ~ n*41 >> 12 for n < 1000
  localparam int HUND_SHIFT   = 12;
  localparam int TENS_RECIP   = 205;         // n/10 ~ n*205 >> 11 for n < 100
  localparam int TENS_SHIFT   = 11;
  localparam int REM_W        = 7;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [PEAK_W-1:0] peak;
    logic [SUM_W-1:0]  sum;
  } mphs_entry_t;

endpackage

FILE: rtl/mphs_if.sv
// Request and result channel interfaces of the peak-hold score block.
// Depends on mphs_pkg for field widths.
interface mphs_in_if import mphs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [CH_W-1:0]   channel;
  logic [SMP_W-1:0]  sample;

  modport source (output valid, cmd, channel, sample, input ready);
  modport sink   (input valid, cmd, channel, sample, output ready);
endinterface

interface mphs_out_if import mphs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PEAK_W-1:0]  peak;
  logic [SCORE_W-1:0] score;
  logic               digit_thousands;
  logic [DIG_W-1:0]   digit_hundreds;
  logic [DIG_W-1:0]   digit_tens;
  logic [DIG_W-1:0]   digit_ones;

  modport source (output valid, peak, score, digit_thousands, digit_hundreds,
                  digit_tens, digit_ones, input ready);
  modport sink   (input valid, peak, score, digit_thousands, digit_hundreds,
                  digit_tens, digit_ones, output ready);
endinterface

FILE: rtl/mphs_front.sv
// Front end: accepts requests, updates per-channel peaks and the running sum.
// Depends on mphs_pkg and mphs_in_if; feeds mphs_queue.
module mphs_front import mphs_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mphs_in_if.sink      in_ch,
  input  logic         q_ready,
  output logic         push,
  output mphs_entry_t  push_data
);

  localparam int DEPTH = (CHANNELS > MAX_DEPTH) ? MAX_DEPTH : CHANNELS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CH_W:0] DEPTH_V = (CH_W+1)'(DEPTH);

  logic [PEAK_W-1:0] store_r [DEPTH];
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              accept, clear, in_range, raise;
  logic [IDX_W-1:0]  idx;
  logic [PEAK_W-1:0] old_pk, new_pk;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid & q_ready;
  assign clear       = (in_ch.cmd == CMD_CLEAR);
  assign in_range    = ({1'b0, in_ch.channel} < DEPTH_V);
  assign idx         = in_ch.channel[IDX_W-1:0];
  assign old_pk      = in_range ? store_r[idx] : '0;
  assign raise       = !clear && in_range && (in_ch.sample > old_pk);
  assign new_pk      = raise ? in_ch.sample : old_pk;

  always_comb begin
    if (clear) begin
      sum_nxt = '0;
    end else if (raise) begin
      sum_nxt = sum_r + SUM_W'(in_ch.sample - old_pk);
    end else begin
      sum_nxt = sum_r;
    end
  end

  assign push           = accept;
  assign push_data.peak = clear ? '0 : new_pk;
  assign push_data.sum  = sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) store_r[i] <= '0;
      sum_r <= '0;
    end else if (accept) begin
      if (clear) begin
        for (int i = 0; i < DEPTH; i++) store_r[i] <= '0;
      end else if (raise) begin
        store_r[idx] <= in_ch.sample;
      end
      sum_r <= sum_nxt;
    end
  end

endmodule

FILE: rtl/mphs_queue.sv
// Small FIFO between the peak-update front end and the score pipeline.
// Depends on mphs_pkg for the entry type.
`include "multichannel_peak_hold_score_top_defines.svh"

module mphs_queue import mphs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  mphs_entry_t  push_data,
  output logic         q_ready,
  input  logic         pop,
  output logic         q_valid,
  output mphs_entry_t  pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mphs_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign q_ready  = (count_r != CNT_FULL);
  assign q_valid  = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    if (!push && pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  `MPHS_ASSERT_NEVER(a_q_overfill, clk, rst_n, count_r > CNT_FULL)
  `MPHS_ASSERT(a_q_grow, clk, rst_n, push && !pop |=> count_r == $past(count_r) + CNT_W'(1))
  `MPHS_ASSERT(a_q_shrink, clk, rst_n, !push && pop |=> count_r == $past(count_r) - CNT_W'(1))

endmodule

FILE: rtl/mphs_back.sv
// Back end: six-stage score pipeline (scale by 8/51, saturate, decimal split).
// Depends on mphs_pkg and mphs_out_if; drains mphs_queue.
`include "multichannel_peak_hold_score_top_defines.svh"

module mphs_back import mphs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  mphs_entry_t  q_data,
  output logic         pop,
  mphs_out_if.source   out_ch
);

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  // stage payloads
  logic [PEAK_W-1:0]  pk1_r, pk2_r, pk3_r, pk4_r, pk5_r, pk6_r;
  logic [X_W-1:0]     x1_r;
  logic [Q0_W-1:0]    q01_r;
  logic [SCORE_W-1:0] sc2_r, sc3_r, sc4_r, sc5_r, sc6_r;
  logic               th3_r, th4_r, th5_r, th6_r;
  logic [SCORE_W-1:0] r13_r;
  logic [DIG_W-1:0]   h3_r, h4_r, h5_r, h6_r;
  logic [REM_W-1:0]   rem4_r, rem5_r;
  logic [DIG_W-1:0]   t5_r, t6_r, o6_r;

  // combinational per stage
  logic [X_W-1:0]        x;
  logic [PROD_W-1:0]     prod;
  logic [X_W:0]          qd, rem;
  logic [Q0_W-1:0]       q_adj;
  logic [SCORE_W-1:0]    sc_sat;
  logic                  th;
  logic [SCORE_W-1:0]    r1;
  logic [SCORE_W+5:0]    hprod;
  logic [REM_W-1:0]      rem2;
  logic [REM_W+7:0]      tprod;
  logic [DIG_W-1:0]      ones;

  // whole pipeline moves together; it freezes, bubbles included, while the output waits
  assign en  = !v6_r || out_ch.ready;
  assign pop = en && q_valid;

  assign x    = {q_data.sum, {SCALE_SHIFT{1'b0}}};
  assign prod = PROD_W'(x) * PROD_W'(RECIP);

  // q01 is the true quotient or one short; remainder stays below 2*51
  assign qd    = (X_W+1)'(q01_r) * (X_W+1)'(DIV_Q);
  assign rem   = (X_W+1)'(x1_r) - qd;
  assign q_adj = q01_r + {{(Q0_W-1){1'b0}}, (rem >= (X_W+1)'(DIV_Q))};
  assign sc_sat = (q_adj > Q0_W'(SCORE_MAX)) ? SCORE_W'(SCORE_MAX) : SCORE_W'(q_adj);

  assign th    = (sc2_r == SCORE_W'(SCORE_MAX));
  assign r1    = th ? '0 : sc2_r;
  assign hprod = (SCORE_W+6)'(r1) * (SCORE_W+6)'(HUND_RECIP);

  assign rem2  = REM_W'(r13_r - SCORE_W'(h3_r) * SCORE_W'(HUND));
  assign tprod = (REM_W+8)'(rem4_r) * (REM_W+8)'(TENS_RECIP);
  assign ones  = DIG_W'(rem5_r - REM_W'(t5_r) * REM_W'(TEN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pk1_r  <= q_data.peak;
      x1_r   <= x;
      q01_r  <= Q0_W'(prod >> RECIP_SHIFT);

      pk2_r  <= pk1_r;
      sc2_r  <= sc_sat;

      pk3_r  <= pk2_r;
      sc3_r  <= sc2_r;
      th3_r  <= th;
      r13_r  <= r1;
      h3_r   <= DIG_W'(hprod >> HUND_SHIFT);

      pk4_r  <= pk3_r;
      sc4_r  <= sc3_r;
      th4_r  <= th3_r;
      h4_r   <= h3_r;
      rem4_r <= rem2;

      pk5_r  <= pk4_r;
      sc5_r  <= sc4_r;
      th5_r  <= th4_r;
      h5_r   <= h4_r;
      rem5_r <= rem4_r;
      t5_r   <= DIG_W'(tprod >> TENS_SHIFT);

      pk6_r  <= pk5_r;
      sc6_r  <= sc5_r;
      th6_r  <= th5_r;
      h6_r   <= h5_r;
      t6_r   <= t5_r;
      o6_r   <= ones;
    end
  end

  assign out_ch.valid           = v6_r;
  assign out_ch.peak            = pk6_r;
  assign out_ch.score           = sc6_r;
  assign out_ch.digit_thousands = th6_r;
  assign out_ch.digit_hundreds  = h6_r;
  assign out_ch.digit_tens      = t6_r;
  assign out_ch.digit_ones      = o6_r;

  `MPHS_ASSERT(a_score_range, clk, rst_n, out_ch.valid |-> out_ch.score <= SCORE_W'(SCORE_MAX))
  `MPHS_ASSERT(a_digits_match, clk, rst_n, out_ch.valid |-> (SCORE_W+1)'(out_ch.score) == (SCORE_W+1)'(out_ch.digit_thousands) * (SCORE_W+1)'(SCORE_MAX) + (SCORE_W+1)'(out_ch.digit_hundreds) * (SCORE_W+1)'(HUND) + (SCORE_W+1)'(out_ch.digit_tens) * (SCORE_W+1)'(TEN) + (SCORE_W+1)'(out_ch.digit_ones))
  `MPHS_ASSERT(a_full_scale, clk, rst_n, out_ch.valid && out_ch.digit_thousands |-> out_ch.digit_hundreds == '0 && out_ch.digit_tens == '0 && out_ch.digit_ones == '0)

endmodule

FILE: rtl/multichannel_peak_hold_score_top.sv
// Channel    Dir  Handshake      Payload
// in_ch      in   valid/ready    cmd, channel, sample
// out_ch     out  valid/ready    peak, score, digit_thousands/hundreds/tens/ones
//
// One request per cycle while the queue has room; the rate is set by the peak/sum
// update in the front end. A result passes the queue write, then six score stages,
// before out_ch.valid rises for it; a stalled output holds it back further.
// Reset is synchronous; all peaks are flops cleared at once.
// A 4-entry queue separates front and score pipeline; a stalled output freezes
// the pipeline and in_ch.ready falls only once the queue is full.
module multichannel_peak_hold_score_top import mphs_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mphs_in_if.sink     in_ch,
  mphs_out_if.source  out_ch
);

  logic        q_ready, push, pop, q_valid;
  mphs_entry_t push_data, q_data;

  mphs_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_ready   (q_ready),
    .push      (push),
    .push_data (push_data)
  );

  mphs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_data  (q_data)
  );

  mphs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: tb/tb_multichannel_peak_hold_score_top.sv
// Testbench for multichannel_peak_hold_score_top: directed table, then random bursts.
// A local peak/sum model predicts each untyped result. Depends on mphs_pkg, mphs_if.sv and the RTL.
module tb_multichannel_peak_hold_score_top;
  import mphs_pkg::*;

  localparam int SCORE_SCALE = 1000;
  localparam int FULL_SUM    = 6375;     // 25 channels at full scale
  localparam int LATENCY     = 6;
  localparam int PHASE_ITEMS = 430;
  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS    = 20;

  typedef struct packed {
    logic [PEAK_W-1:0]  peak;
    logic [SCORE_W-1:0] score;
    logic               thousands;
    logic [DIG_W-1:0]   hundreds;
    logic [DIG_W-1:0]   tens;
    logic [DIG_W-1:0]   ones;
  } score_row_t;

  typedef struct packed {
    cmd_t               op;
    logic [CH_W-1:0]    chan;
    logic [SMP_W-1:0]   value;
    logic               typed;
    logic [PEAK_W-1:0]  t_peak;
    logic [SCORE_W-1:0] t_score;
  } stim_row_t;

  // typed rows carry the result read straight off the spec; the rest use the model
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{CMD_SAMPLE, 5'd0,  8'd0,   1'b1, 8'd0,   10'd0},
    '{CMD_SAMPLE, 5'd24, 8'd255, 1'b1, 8'd255, 10'd40},
    '{CMD_SAMPLE, 5'd24, 8'd17,  1'b1, 8'd255, 10'd40},   // lower value keeps peak
    '{CMD_SAMPLE, 5'd31, 8'd255, 1'b1, 8'd0,   10'd40},   // channel out of range
    '{CMD_SAMPLE, 5'd25, 8'd200, 1'b1, 8'd0,   10'd40},
    '{CMD_SAMPLE, 5'd0,  8'd1,   1'b1, 8'd1,   10'd40},
    '{CMD_SAMPLE, 5'd12, 8'd170, 1'b0, 8'd0,   10'd0},
    '{CMD_SAMPLE, 5'd7,  8'd85,  1'b0, 8'd0,   10'd0},
    '{CMD_SAMPLE, 5'd16, 8'd128, 1'b0, 8'd0,   10'd0},
    '{CMD_SAMPLE, 5'd1,  8'd255, 1'b0, 8'd0,   10'd0},
    '{CMD_CLEAR,  5'd31, 8'd255, 1'b1, 8'd0,   10'd0},   // clear ignores fields
    '{CMD_SAMPLE, 5'd24, 8'd0,   1'b1, 8'd0,   10'd0},
    '{CMD_CLEAR,  5'd0,  8'd0,   1'b1, 8'd0,   10'd0},
    '{CMD_SAMPLE, 5'd15, 8'd255, 1'b1, 8'd255, 10'd40},
    '{CMD_SAMPLE, 5'd8,  8'd255, 1'b1, 8'd255, 10'd80},
    '{CMD_SAMPLE, 5'd8,  8'd254, 1'b1, 8'd255, 10'd80},
    '{CMD_SAMPLE, 5'd2,  8'd127, 1'b0, 8'd0,   10'd0},
    '{CMD_SAMPLE, 5'd30, 8'd0,   1'b0, 8'd0,   10'd0},
    '{CMD_CLEAR,  5'd10, 8'd99,  1'b1, 8'd0,   10'd0},
    '{CMD_SAMPLE, 5'd10, 8'd99,  1'b0, 8'd0,   10'd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  mphs_in_if  in_ch ();
  mphs_out_if out_ch ();

  multichannel_peak_hold_score_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // model state
  logic [PEAK_W-1:0] held_peak [CHANNELS_DEF];
  int unsigned       peak_total;
  score_row_t        pending_scores [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_len       = 0;
  int errors         = 0;
  int phase_sent     = 0;
  int total_reqs     = 0;
  int clear_reqs     = 0;
  int stray_reqs     = 0;
  int full_scale     = 0;
  int cycle_count    = 0;

  function automatic score_row_t make_result(logic [PEAK_W-1:0] pk, int unsigned sc);
    score_row_t r;
    r.peak      = pk;
    r.score     = sc[SCORE_W-1:0];
    r.thousands = (sc / 1000) != 0;
    r.hundreds  = DIG_W'((sc % 1000) / HUND);
    r.tens      = DIG_W'((sc % HUND) / TEN);
    r.ones      = DIG_W'(sc % TEN);
    return r;
  endfunction

  function automatic score_row_t update_peaks(cmd_t op, logic [CH_W-1:0] chan,
                                              logic [SMP_W-1:0] value);
    logic [PEAK_W-1:0] pk;
    int unsigned       sc;
    pk = '0;
    if (op == CMD_CLEAR) begin
      foreach (held_peak[i]) held_peak[i] = '0;
      peak_total = 0;
    end else if (int'(chan) < CHANNELS_DEF) begin
      if (value > held_peak[chan]) begin
        peak_total = peak_total + int'(value) - int'(held_peak[chan]);
        held_peak[chan] = value;
      end
      pk = held_peak[chan];
    end
    sc = peak_total * SCORE_SCALE / FULL_SUM;
    if (sc > SCORE_MAX) sc = SCORE_MAX;
    return make_result(pk, sc);
  endfunction

  task automatic push_req(cmd_t op, logic [CH_W-1:0] chan, logic [SMP_W-1:0] value,
                          logic typed, logic [PEAK_W-1:0] t_peak,
                          logic [SCORE_W-1:0] t_score);
    score_row_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= op;
    in_ch.channel <= chan;
    in_ch.sample  <= value;
    do @(posedge clk); while (!in_ch.ready);
    want = update_peaks(op, chan, value);
    if (typed) want = make_result(t_peak, 32'(t_score));
    pending_scores.push_back(want);
    total_reqs++;
    phase_sent++;
    if (op == CMD_CLEAR) clear_reqs++;
    else if (int'(chan) >= CHANNELS_DEF) stray_reqs++;
    if (want.score == SCORE_W'(SCORE_MAX)) full_scale++;
  endtask

  task automatic push_sample(logic [CH_W-1:0] chan, logic [SMP_W-1:0] value);
    push_req(CMD_SAMPLE, chan, value, 1'b0, '0, '0);
  endtask

  // one burst of related requests: clear, full sweep, sample run or noise
  task automatic random_burst();
    int                kind;
    int                n;
    logic [CH_W-1:0]   chan;
    logic [SMP_W-1:0]  value;
    kind = $urandom_range(99);
    if (kind < 8) begin
      push_req(CMD_CLEAR, CH_W'($urandom), SMP_W'($urandom), 1'b0, '0, '0);
    end else if (kind < 20) begin
      // sweep toward full scale; most channels pinned at 255
      for (int c = 0; c < CHANNELS_DEF; c++) begin
        value = ($urandom_range(5) == 0) ? SMP_W'($urandom) : 8'hFF;
        push_sample(CH_W'(c), value);
      end
    end else if (kind < 25) begin
      push_req(cmd_t'($urandom_range(1)), CH_W'($urandom), SMP_W'($urandom),
               1'b0, '0, '0);
    end else begin
      n = $urandom_range(16, 1);
      repeat (n) begin
        chan = ($urandom_range(15) == 0) ? CH_W'($urandom_range(31, CHANNELS_DEF))
                                         : CH_W'($urandom_range(CHANNELS_DEF - 1));
        case ($urandom_range(9))
          0:       value = '0;
          1, 2:    value = 8'hFF;
          3:       value = SMP_W'($urandom_range(255, 200));
          default: value = SMP_W'($urandom);
        endcase
        push_sample(chan, value);
      end
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // result side: check, then pick next ready (long hold-off overrides random stalls)
  initial begin
    score_row_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_scores.size() == 0) begin
          $error("result with no request pending: peak %0d score %0d",
                 out_ch.peak, out_ch.score);
          errors++;
        end else begin
          want = pending_scores.pop_front();
          check_field("peak", 32'(want.peak), 32'(out_ch.peak));
          check_field("score", 32'(want.score), 32'(out_ch.score));
          check_field("digit_thousands", 32'(want.thousands),
                      32'(out_ch.digit_thousands));
          check_field("digit_hundreds", 32'(want.hundreds), 32'(out_ch.digit_hundreds));
          check_field("digit_tens", 32'(want.tens), 32'(out_ch.digit_tens));
          check_field("digit_ones", 32'(want.ones), 32'(out_ch.digit_ones));
        end
      end
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        hold_len--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    foreach (held_peak[i]) held_peak[i] = '0;
    peak_total = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= CMD_SAMPLE;
    in_ch.channel <= '0;
    in_ch.sample  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i])
      push_req(DIRECTED[i].op, DIRECTED[i].chan, DIRECTED[i].value,
               DIRECTED[i].typed, DIRECTED[i].t_peak, DIRECTED[i].t_score);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      phase_sent = 0;
      if (ph == 0) begin
        // receiver holds off while requests keep coming: queue fills, input stalls
        hold_len = HOLD_CYCLES;
        repeat (40) push_sample(CH_W'($urandom_range(CHANNELS_DEF - 1)), SMP_W'($urandom));
      end
      while (phase_sent < PHASE_ITEMS) random_burst();
      // sender goes quiet until the pipeline drains
      in_ch.valid <= 1'b0;
      wait (pending_scores.size() == 0);
      @(posedge clk);
    end

    in_ch.valid <= 1'b0;
    wait (pending_scores.size() == 0);
    repeat (LATENCY * 4) @(posedge clk);

    $display("Ran %0d requests (%0d clears, %0d out-of-range channels), %0d at full score,",
             total_reqs, clear_reqs, stray_reqs, full_scale);
    $display("across free-running, sender-idle, receiver-stall and mixed pacing phases.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
